// File: design/prd_pkg.sv
// Package for the pinhole ray direction block.
// Holds the shared widths, configuration register codes, pipeline side-band types and the
// basis-vector component extraction. No dependencies.
package prd_pkg;

  // Field and register widths
  localparam int PIX_W     = 12;
  localparam int OUT_W     = 16;
  localparam int VEC_W     = 63;
  localparam int COMP_W    = 21;
  localparam int CFG_W     = 63;
  localparam int CFG_IDX_W = 3;
  localparam int CTR_W     = 16;
  localparam int INV_W     = 24;

  // Fraction bits of the scaled offset, which is also the shift applied to the forward vector
  localparam int P_FRAC = 20;

  // Normalized magnitudes sit in [2^MAG_TOP, 2^(MAG_TOP+1))
  localparam int MAG_TOP = 28;
  localparam int MAG_W   = MAG_TOP + 1;
  localparam int SUM_W   = 2 * MAG_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  // The reciprocal is 2^NUM_EXP / root, at most 2^(NUM_EXP - MAG_TOP)
  localparam int NUM_EXP = 2 * ROOT_W;
  localparam int RCP_W   = NUM_EXP - MAG_TOP + 1;
  localparam int PROD_W  = MAG_W + RCP_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CTR_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTR_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GL_MODE = 3'd7;

  // Reset values of the basis vectors
  localparam logic [VEC_W-1:0] RIGHT_RST   = 63'd524288;
  localparam logic [VEC_W-1:0] UP_RST      = 63'd1099511627776;
  localparam logic [VEC_W-1:0] FORWARD_RST = 63'd2305843009213693952;
  localparam logic [INV_W-1:0] INV_RST     = 24'd16384;

  // Side-band data that travels with an item through the root and reciprocal pipelines
  typedef struct packed {
    logic                        zero;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
  } side_t;

  // One result item
  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
  } dir_t;

  // Signed Q1.19 component k of a packed basis vector
  function automatic logic signed [COMP_W-1:0] vec_comp(input logic [VEC_W-1:0] v,
                                                        input int unsigned k);
    return v[COMP_W*k +: COMP_W];
  endfunction

endpackage

// File: design/prd_pix_if.sv
// Pixel coordinate channel of the pinhole ray direction block.
// Depends on prd_pkg for the field width.
interface prd_pix_if;
  logic                        valid;
  logic                        ready;
  logic [prd_pkg::PIX_W-1:0]   pixel_col;
  logic [prd_pkg::PIX_W-1:0]   pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

// File: design/prd_dir_if.sv
// Ray direction channel of the pinhole ray direction block.
// Depends on prd_pkg for the field width.
interface prd_dir_if;
  logic                               valid;
  logic                               ready;
  logic signed [prd_pkg::OUT_W-1:0]   dir_x;
  logic signed [prd_pkg::OUT_W-1:0]   dir_y;
  logic signed [prd_pkg::OUT_W-1:0]   dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

// File: design/prd_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on prd_pkg for widths and the side-band type.
module prd_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic [prd_pkg::SUM_W-1:0]     in_sum_i,
  input  prd_pkg::side_t                in_side_i,
  output logic                          out_valid_o,
  output logic [prd_pkg::ROOT_W-1:0]    out_root_o,
  output prd_pkg::side_t                out_side_o
);

  localparam int Steps = prd_pkg::ROOT_W;
  localparam int RW    = prd_pkg::SUM_W + 2;

  logic           vld_q  [Steps];
  logic [RW-1:0]  rem_q  [Steps];
  logic [RW-1:0]  root_q [Steps];
  prd_pkg::side_t side_q [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam logic [RW-1:0] Bit = RW'(1) << (2 * (Steps - 1 - s));

    logic           pv;
    logic [RW-1:0]  prem;
    logic [RW-1:0]  proot;
    logic [RW-1:0]  trial;
    prd_pkg::side_t pside;

    if (s == 0) begin : g_first
      assign pv    = in_valid_i;
      assign prem  = RW'(in_sum_i);
      assign proot = '0;
      assign pside = in_side_i;
    end else begin : g_next
      assign pv    = vld_q[s-1];
      assign prem  = rem_q[s-1];
      assign proot = root_q[s-1];
      assign pside = side_q[s-1];
    end

    // Trial subtraction of the next root bit.
    assign trial = proot + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= pside;
        if (prem >= trial) begin
          rem_q[s]  <= prem - trial;
          root_q[s] <= (proot >> 1) + Bit;
        end else begin
          rem_q[s]  <= prem;
          root_q[s] <= proot >> 1;
        end
      end
    end
  end

  assign out_valid_o = vld_q[Steps-1];
  assign out_root_o  = root_q[Steps-1][prd_pkg::ROOT_W-1:0];
  assign out_side_o  = side_q[Steps-1];

endmodule

// File: design/prd_recip.sv
// Pipelined restoring divider that forms 2^60 / root, one quotient bit per stage.
// Depends on prd_pkg for widths and the side-band type.
module prd_recip (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic [prd_pkg::ROOT_W-1:0]    in_root_i,
  input  prd_pkg::side_t                in_side_i,
  output logic                          out_valid_o,
  output logic [prd_pkg::RCP_W-1:0]     out_recip_o,
  output prd_pkg::side_t                out_side_o
);

  localparam int Steps = prd_pkg::RCP_W;
  localparam int LW    = prd_pkg::ROOT_W;
  // Partial remainder before the top quotient bit: the dividend bits above it
  localparam logic [LW-1:0] RemInit = LW'(1) << (prd_pkg::NUM_EXP - Steps);

  logic             vld_q  [Steps];
  logic [LW-1:0]    rem_q  [Steps];
  logic [LW-1:0]    div_q  [Steps];
  logic [Steps-1:0] quo_q  [Steps];
  prd_pkg::side_t   side_q [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic             pv;
    logic [LW-1:0]    prem;
    logic [LW-1:0]    pdiv;
    logic [Steps-1:0] pquo;
    prd_pkg::side_t   pside;
    logic [LW:0]      shifted;
    logic             take;

    if (s == 0) begin : g_first
      assign pv    = in_valid_i;
      assign prem  = RemInit;
      assign pdiv  = in_root_i;
      assign pquo  = '0;
      assign pside = in_side_i;
    end else begin : g_next
      assign pv    = vld_q[s-1];
      assign prem  = rem_q[s-1];
      assign pdiv  = div_q[s-1];
      assign pquo  = quo_q[s-1];
      assign pside = side_q[s-1];
    end

    // Bring in a zero dividend bit and try to subtract the divisor.
    assign shifted = {prem, 1'b0};
    assign take    = shifted >= {1'b0, pdiv};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= pside;
        div_q[s]  <= pdiv;
        quo_q[s]  <= {pquo[Steps-2:0], take};
        rem_q[s]  <= take ? LW'(shifted - {1'b0, pdiv}) : LW'(shifted);
      end
    end
  end

  assign out_valid_o = vld_q[Steps-1];
  assign out_recip_o = quo_q[Steps-1];
  assign out_side_o  = side_q[Steps-1];

endmodule

// File: design/pinhole_ray_direction.sv
// Top level of the pinhole ray direction block: configuration registers, offset and basis
// arithmetic, normalization, and the output register with its skid stage.
// Depends on prd_pkg, prd_pix_if, prd_dir_if, prd_isqrt and prd_recip.
//
//   Channel   Dir   Handshake        Payload
//   pix_i     in    valid/ready      pixel_col, pixel_row
//   dir_o     out   valid/ready      dir_x, dir_y, dir_z
//   cfg       in    cfg_we_i         cfg_idx_i, cfg_data_i
//
// One pixel is taken every cycle while the skid register is empty.
// The pipeline holds the square root (30 stages) and the reciprocal divider (33 stages),
// each producing one bit per stage, plus 12 arithmetic and output stages.
// Reset clears all valid bits and loads the configuration reset values.
// A stalled output fills a one-entry skid register; the whole pipeline then holds until the
// skid drains, so nothing is lost or repeated.
module pinhole_ray_direction #(
  parameter int COORD_BITS    = 12,
  parameter int DIR_FRAC_BITS = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [prd_pkg::CFG_W-1:0]         cfg_data_i,
  prd_pix_if.sink                           pix_i,
  prd_dir_if.source                         dir_o
);

  // Offset width: 16*pixel + 8 minus a 16-bit center, signed
  localparam int DW  = ((COORD_BITS + 4 > prd_pkg::CTR_W) ? COORD_BITS + 4
                                                          : prd_pkg::CTR_W) + 1;
  localparam int PW  = DW + prd_pkg::INV_W + 1 - 8;
  localparam int AW  = PW + prd_pkg::COMP_W;
  localparam int VW  = PW + prd_pkg::COMP_W + 2;
  localparam int G   = (VW + 7) / 8;
  localparam int PSW = $clog2(G * 8);
  localparam int SW  = VW + prd_pkg::MAG_TOP;
  localparam int Rs  = prd_pkg::NUM_EXP - 1 - DIR_FRAC_BITS;
  localparam int Lim = (DIR_FRAC_BITS >= 15) ? 32767 : (1 << DIR_FRAC_BITS) - 1;

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  logic [prd_pkg::VEC_W-1:0] right_q, up_q, fwd_q;
  logic [prd_pkg::CTR_W-1:0] cx_q, cy_q;
  logic [prd_pkg::INV_W-1:0] ifx_q, ify_q;
  logic                      gl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= prd_pkg::RIGHT_RST;
      up_q    <= prd_pkg::UP_RST;
      fwd_q   <= prd_pkg::FORWARD_RST;
      cx_q    <= '0;
      cy_q    <= '0;
      ifx_q   <= prd_pkg::INV_RST;
      ify_q   <= prd_pkg::INV_RST;
      gl_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        prd_pkg::CFG_RIGHT:   right_q <= cfg_data_i;
        prd_pkg::CFG_UP:      up_q    <= cfg_data_i;
        prd_pkg::CFG_FORWARD: fwd_q   <= cfg_data_i;
        prd_pkg::CFG_CTR_X:   cx_q    <= cfg_data_i[prd_pkg::CTR_W-1:0];
        prd_pkg::CFG_CTR_Y:   cy_q    <= cfg_data_i[prd_pkg::CTR_W-1:0];
        prd_pkg::CFG_INV_X:   ifx_q   <= cfg_data_i[prd_pkg::INV_W-1:0];
        prd_pkg::CFG_INV_Y:   ify_q   <= cfg_data_i[prd_pkg::INV_W-1:0];
        prd_pkg::CFG_GL_MODE: gl_q    <= cfg_data_i[0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline control: every stage moves together while the skid register is empty.
  logic skid_vld_q;
  logic en;

  assign en          = !skid_vld_q;
  assign pix_i.ready = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, vm_q;
  logic sq_valid, rc_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      vm_q  <= 1'b0;
    end else if (en) begin
      v1_q  <= pix_i.valid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      vm_q  <= rc_valid;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: offsets of the pixel center from the principal point, in sixteenths.
  logic [15:0]          col_ext, row_ext;
  logic signed [DW-1:0] dx_q, dy_q;

  assign col_ext = 16'(pix_i.pixel_col);
  assign row_ext = 16'(pix_i.pixel_row);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= DW'({col_ext[COORD_BITS-1:0], 4'b1000}) - DW'(cx_q);
      dy_q <= DW'({row_ext[COORD_BITS-1:0], 4'b1000}) - DW'(cy_q);
    end
  end

  // Stage 2: scale by the reciprocal focal lengths; the arithmetic shift floors.
  logic signed [DW+prd_pkg::INV_W:0] prod_x, prod_y;
  logic signed [PW-1:0]              px_q, py_q;

  assign prod_x = dx_q * $signed({1'b0, ifx_q});
  assign prod_y = dy_q * $signed({1'b0, ify_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= prod_x[DW+prd_pkg::INV_W:8];
      py_q <= prod_y[DW+prd_pkg::INV_W:8];
    end
  end

  // Stage 3: right and up vectors times the scaled offsets.
  logic signed [AW-1:0] a_q [3];
  logic signed [AW-1:0] b_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_q[k] <= prd_pkg::vec_comp(right_q, k) * px_q;
        b_q[k] <= prd_pkg::vec_comp(up_q, k) * py_q;
      end
    end
  end

  // Stage 4: direction sum, split into sign and magnitude. OpenGL mode subtracts the up term.
  logic signed [VW-1:0]  vsum [3];
  logic [2:0][VW-1:0]    mag4_q, mag5_q, mag6_q, mag7_q;
  logic [2:0]            neg4_q, neg5_q, neg6_q, neg7_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vsum[k] = (VW'(prd_pkg::vec_comp(fwd_q, k)) <<< prd_pkg::P_FRAC) + VW'(a_q[k])
              + (gl_q ? -VW'(b_q[k]) : VW'(b_q[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg4_q[k] <= vsum[k][VW-1];
        mag4_q[k] <= vsum[k][VW-1] ? VW'(-vsum[k]) : VW'(vsum[k]);
      end
    end
  end

  // Stage 5: largest magnitude.
  logic [VW-1:0] m01, mmax_q;

  assign m01 = (mag4_q[1] > mag4_q[0]) ? mag4_q[1] : mag4_q[0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mmax_q <= (mag4_q[2] > m01) ? mag4_q[2] : m01;
      mag5_q <= mag4_q;
      neg5_q <= neg4_q;
    end
  end

  // Stage 6: per-byte nonzero flags and leading-one positions of the largest magnitude.
  logic [G*8-1:0]   mpad;
  logic [G-1:0]     gnz_d, gnz_q;
  logic [G-1:0][2:0] gpos_d, gpos_q;

  assign mpad = (G*8)'(mmax_q);

  always_comb begin
    for (int g = 0; g < G; g++) begin
      gnz_d[g]  = |mpad[8*g +: 8];
      gpos_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (mpad[8*g + b]) begin
          gpos_d[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gnz_q  <= gnz_d;
      gpos_q <= gpos_d;
      mag6_q <= mag5_q;
      neg6_q <= neg5_q;
    end
  end

  // Stage 7: highest nonzero byte gives the leading-one position.
  logic [PSW-1:0] pos_d, pos_q;
  logic           zero7_q;

  always_comb begin
    pos_d = '0;
    for (int g = 0; g < G; g++) begin
      if (gnz_q[g]) begin
        pos_d = PSW'(8 * g) + PSW'(gpos_q[g]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q   <= pos_d;
      zero7_q <= ~|gnz_q;
      mag7_q  <= mag6_q;
      neg7_q  <= neg6_q;
    end
  end

  // Stage 8: shift all magnitudes by one amount so the largest lands in [2^28, 2^29).
  logic [2:0][prd_pkg::MAG_W-1:0] nmag;
  prd_pkg::side_t                 side8_q, side9_q, side10_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pos_q >= PSW'(prd_pkg::MAG_TOP)) begin
        nmag[k] = prd_pkg::MAG_W'(mag7_q[k] >> (pos_q - PSW'(prd_pkg::MAG_TOP)));
      end else begin
        nmag[k] = prd_pkg::MAG_W'(SW'(mag7_q[k]) << (PSW'(prd_pkg::MAG_TOP) - pos_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side8_q.zero <= zero7_q;
      side8_q.neg  <= neg7_q;
      side8_q.mag  <= nmag;
    end
  end

  // Stage 9: squares.
  logic [2:0][2*prd_pkg::MAG_W-1:0] sq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= side8_q.mag[k] * side8_q.mag[k];
      end
      side9_q <= side8_q;
    end
  end

  // Stage 10: sum of squares.
  logic [prd_pkg::SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q    <= prd_pkg::SUM_W'(sq_q[0]) + prd_pkg::SUM_W'(sq_q[1])
                + prd_pkg::SUM_W'(sq_q[2]);
      side10_q <= side9_q;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Length and its reciprocal.
  logic [prd_pkg::ROOT_W-1:0] root;
  prd_pkg::side_t             sq_side, rc_side;
  logic [prd_pkg::RCP_W-1:0]  recip;

  prd_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (v10_q),
    .in_sum_i    (sum_q),
    .in_side_i   (side10_q),
    .out_valid_o (sq_valid),
    .out_root_o  (root),
    .out_side_o  (sq_side)
  );

  prd_recip u_recip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (sq_valid),
    .in_root_i   (root),
    .in_side_i   (sq_side),
    .out_valid_o (rc_valid),
    .out_recip_o (recip),
    .out_side_o  (rc_side)
  );

  // Scale each magnitude by the reciprocal length.
  logic [2:0][prd_pkg::PROD_W-1:0] mprod_q;
  logic [2:0]                      negm_q;
  logic                            zerom_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mprod_q[k] <= prd_pkg::PROD_W'(rc_side.mag[k]) * prd_pkg::PROD_W'(recip);
      end
      negm_q  <= rc_side.neg;
      zerom_q <= rc_side.zero;
    end
  end

  // Round half away from zero on the magnitude, saturate, and apply the sign.
  logic [prd_pkg::PROD_W:0]  qsum [3];
  logic [prd_pkg::PROD_W:0]  qv   [3];
  logic [prd_pkg::OUT_W-1:0] comp_out [3];
  prd_pkg::dir_t             res;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qsum[k] = (prd_pkg::PROD_W+1)'(mprod_q[k]) + ((prd_pkg::PROD_W+1)'(1) << Rs);
      qv[k]   = qsum[k] >> (Rs + 1);
      if (zerom_q) begin
        comp_out[k] = '0;
      end else if (negm_q[k]) begin
        if (qv[k] > (prd_pkg::PROD_W+1)'(Lim + 1)) begin
          comp_out[k] = -prd_pkg::OUT_W'(Lim + 1);
        end else begin
          comp_out[k] = -prd_pkg::OUT_W'(qv[k]);
        end
      end else begin
        if (qv[k] > (prd_pkg::PROD_W+1)'(Lim)) begin
          comp_out[k] = prd_pkg::OUT_W'(Lim);
        end else begin
          comp_out[k] = prd_pkg::OUT_W'(qv[k]);
        end
      end
    end
    res.x = comp_out[0];
    res.y = comp_out[1];
    res.z = comp_out[2];
  end

  // ---------------------------------------------------------------------------------------
  // Output register and skid register.
  logic          out_vld_q;
  prd_pkg::dir_t out_q, skid_q;
  logic          out_free;

  assign out_free = !out_vld_q || dir_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (en) begin
      if (vm_q) begin
        if (out_free) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (dir_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end else if (dir_o.ready) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (vm_q) begin
        if (out_free) begin
          out_q <= res;
        end else begin
          skid_q <= res;
        end
      end
    end else if (dir_o.ready) begin
      out_q <= skid_q;
    end
  end

  assign dir_o.valid = out_vld_q;
  assign dir_o.dir_x = out_q.x;
  assign dir_o.dir_y = out_q.y;
  assign dir_o.dir_z = out_q.z;

endmodule

// File: sim/tb_pinhole_ray_direction.sv
// Testbench for the pinhole ray direction block: directed table and corner cases, then random
// pixels under several camera settings, all checked against an in-bench ray predictor.
// Depends on prd_pkg, prd_pix_if, prd_dir_if and the pinhole_ray_direction RTL.
module tb_pinhole_ray_direction;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 15;
  localparam int PIPE_LAT = 75;

  typedef logic [prd_pkg::PIX_W-1:0] pix_t;
  typedef logic [prd_pkg::CFG_W-1:0] cfg_t;
  typedef logic [prd_pkg::VEC_W-1:0] vec_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [prd_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [prd_pkg::CFG_W-1:0] cfg_data_i;

  prd_pix_if pix ();
  prd_dir_if dir ();

  pinhole_ray_direction u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .pix_i(pix.sink), .dir_o(dir.source)
  );

  // Camera state mirrored in the bench
  logic [prd_pkg::VEC_W-1:0] cam_right, cam_up, cam_fwd;
  logic [prd_pkg::CTR_W-1:0] cam_cx, cam_cy;
  logic [prd_pkg::INV_W-1:0] cam_ifx, cam_ify;
  logic cam_gl;

  prd_pkg::dir_t ray_queue[$];
  int unsigned err_count = 0;
  bit stall_en = 1;

  // Directed rows; chk marks rows whose result is typed in
  typedef struct packed {
    logic [prd_pkg::PIX_W-1:0] col;
    logic [prd_pkg::PIX_W-1:0] row;
    bit chk;
    prd_pkg::dir_t ray;
  } pix_row_t;

  pix_row_t dir_tbl[$];

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic prd_pkg::dir_t ray_of(logic [prd_pkg::OUT_W-1:0] x,
                                           logic [prd_pkg::OUT_W-1:0] y,
                                           logic [prd_pkg::OUT_W-1:0] z);
    prd_pkg::dir_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  function automatic void add_row(pix_t col, pix_t row, bit chk, prd_pkg::dir_t ray);
    pix_row_t r;
    r.col = col;
    r.row = row;
    r.chk = chk;
    r.ray = ray;
    dir_tbl = {dir_tbl, r};
  endfunction

  function automatic void enqueue_ray(prd_pkg::dir_t ray);
    ray_queue = {ray_queue, ray};
  endfunction

  function automatic longint comp_of(logic [prd_pkg::VEC_W-1:0] v, int k);
    logic signed [prd_pkg::COMP_W-1:0] c;
    c = v[prd_pkg::COMP_W*k +: prd_pkg::COMP_W];
    return longint'(c);
  endfunction

  function automatic longint pix_offset(logic [prd_pkg::PIX_W-1:0] p,
                                        logic [prd_pkg::CTR_W-1:0] c,
                                        logic [prd_pkg::INV_W-1:0] inv);
    longint d;
    d = (longint'(p) * 16 + 8 - longint'(c)) * longint'(inv);
    return d >>> 8;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Unit ray for one pixel under the current camera
  function automatic prd_pkg::dir_t predict_ray(pix_t col, pix_t row);
    longint ox, oy, v;
    logic [63:0] mag[3];
    bit neg[3];
    logic [63:0] m, sum, len, rcp, q, lim;
    int sr, sl;
    prd_pkg::dir_t r;
    logic [prd_pkg::OUT_W-1:0] o[3];
    ox = pix_offset(col, cam_cx, cam_ifx);
    oy = pix_offset(row, cam_cy, cam_ify);
    if (cam_gl) oy = -oy;
    m = 0;
    for (int k = 0; k < 3; k++) begin
      v = comp_of(cam_fwd, k) * (64'sd1 <<< 20) + comp_of(cam_right, k) * ox
          + comp_of(cam_up, k) * oy;
      neg[k] = v < 0;
      mag[k] = neg[k] ? -v : v;
      if (mag[k] > m) m = mag[k];
    end
    if (m == 0) return '0;
    sr = 0;
    sl = 0;
    while (m >= (64'd1 << 29)) begin m >>= 1; sr++; end
    while (m < (64'd1 << 28)) begin m <<= 1; sl++; end
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (mag[k] >> sr) << sl;
      sum += mag[k] * mag[k];
    end
    len = int_sqrt(sum);
    rcp = (64'd1 << 60) / len;
    lim = (64'd1 << FRAC) - 1;
    if (lim > 32767) lim = 32767;
    for (int k = 0; k < 3; k++) begin
      q = (mag[k] * rcp + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
      if (neg[k]) begin
        if (q > lim + 1) q = lim + 1;
        o[k] = -q[prd_pkg::OUT_W-1:0];
      end else begin
        if (q > lim) q = lim;
        o[k] = q[prd_pkg::OUT_W-1:0];
      end
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    return r;
  endfunction

  task automatic write_reg(logic [prd_pkg::CFG_IDX_W-1:0] idx, cfg_t val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      prd_pkg::CFG_RIGHT: cam_right = val;
      prd_pkg::CFG_UP: cam_up = val;
      prd_pkg::CFG_FORWARD: cam_fwd = val;
      prd_pkg::CFG_CTR_X: cam_cx = val[prd_pkg::CTR_W-1:0];
      prd_pkg::CFG_CTR_Y: cam_cy = val[prd_pkg::CTR_W-1:0];
      prd_pkg::CFG_INV_X: cam_ifx = val[prd_pkg::INV_W-1:0];
      prd_pkg::CFG_INV_Y: cam_ify = val[prd_pkg::INV_W-1:0];
      prd_pkg::CFG_GL_MODE: cam_gl = val[0];
      default: ;
    endcase
  endtask

  // Wait until every expected ray has come back
  task automatic drain();
    while (ray_queue.size() != 0) @(posedge clk_i);
  endtask

  // One pixel transfer; a typed-in ray replaces the predicted one
  task automatic send_pixel(pix_t col, pix_t row, bit chk, prd_pkg::dir_t typed);
    prd_pkg::dir_t exp_ray;
    exp_ray = predict_ray(col, row);
    if (chk && exp_ray != typed) begin
      err_count++;
      if (err_count <= 10)
        $display("Predictor disagrees with table for (%0d,%0d): %h vs %h", col, row,
                 exp_ray, typed);
    end
    pix.valid <= 1;
    pix.pixel_col <= col;
    pix.pixel_row <= row;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    enqueue_ray(chk ? typed : exp_ray);
  endtask

  task automatic idle_gap();
    pix.valid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // Bursts of random pixels with random gaps
  task automatic random_pixels(int n);
    int left;
    left = n;
    while (left > 0) begin
      for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--) begin
        send_pixel(pix_t'($urandom), pix_t'($urandom), 1'b0, '0);
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    pix.valid <= 0;
  endtask

  function automatic vec_t rand_vec();
    return vec_t'({$urandom, $urandom});
  endfunction

  // Receiver stall pattern and result check
  always @(posedge clk_i) begin
    prd_pkg::dir_t got, want;
    if (rst_ni) begin
      if (dir.valid && dir.ready) begin
        got.x = dir.dir_x;
        got.y = dir.dir_y;
        got.z = dir.dir_z;
        if (ray_queue.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("Unexpected ray %h", got);
        end else begin
          want = ray_queue.pop_front();
          if (got.x != want.x || got.y != want.y || got.z != want.z) begin
            err_count++;
            if (err_count <= 10)
              $display("Ray mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                       $signed(want.x), $signed(want.y), $signed(want.z),
                       $signed(got.x), $signed(got.y), $signed(got.z));
          end
        end
      end
      dir.ready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
    end else begin
      dir.ready <= 1'b0;
    end
  end

  initial begin
    prd_pkg::dir_t z;
    z = '0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = prd_pkg::CFG_RIGHT;
    cfg_data_i = '0;
    pix.valid = 0;
    pix.pixel_col = 0;
    pix.pixel_row = 0;
    cam_right = prd_pkg::RIGHT_RST;
    cam_up = prd_pkg::UP_RST;
    cam_fwd = prd_pkg::FORWARD_RST;
    cam_cx = 0;
    cam_cy = 0;
    cam_ifx = prd_pkg::INV_RST;
    cam_ify = prd_pkg::INV_RST;
    cam_gl = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Reset camera: at pixel (0,0) the offsets are tiny, so the ray points almost straight ahead
    add_row(12'd0, 12'd0, 1'b1, ray_of(16'd16, 16'd16, 16'd32767));
    add_row(12'd4095, 12'd4095, 1'b0, z);
    add_row(12'd4095, 12'd0, 1'b0, z);
    add_row(12'd0, 12'd4095, 1'b0, z);
    add_row(12'd2048, 12'd1365, 1'b0, z);
    add_row(12'd2730, 12'd2730, 1'b0, z);
    foreach (dir_tbl[i])
      send_pixel(dir_tbl[i].col, dir_tbl[i].row, dir_tbl[i].chk, dir_tbl[i].ray);
    pix.valid <= 0;
    drain();

    // Zero sum vector: all basis vectors zero
    write_reg(prd_pkg::CFG_FORWARD, '0);
    write_reg(prd_pkg::CFG_RIGHT, '0);
    write_reg(prd_pkg::CFG_UP, '0);
    send_pixel(12'd17, 12'd99, 1'b1, z);
    send_pixel(12'd4095, 12'd4095, 1'b1, z);
    pix.valid <= 0;
    drain();

    // Saturation: forward of -2.0 on x only, then the largest positive x component
    write_reg(prd_pkg::CFG_FORWARD, 63'h10_0000);
    send_pixel(12'd0, 12'd0, 1'b1, ray_of(16'h8000, 16'd0, 16'd0));
    pix.valid <= 0;
    drain();
    write_reg(prd_pkg::CFG_FORWARD, 63'h0F_FFFF);
    send_pixel(12'd0, 12'd0, 1'b1, ray_of(16'd32767, 16'd0, 16'd0));
    pix.valid <= 0;
    drain();

    // Extreme optics: huge x and tiny y reciprocal focal, centers at the top, OpenGL sign
    write_reg(prd_pkg::CFG_RIGHT, prd_pkg::RIGHT_RST);
    write_reg(prd_pkg::CFG_UP, prd_pkg::UP_RST);
    write_reg(prd_pkg::CFG_FORWARD, prd_pkg::FORWARD_RST);
    write_reg(prd_pkg::CFG_INV_X, cfg_t'(24'hFF_FFFF));
    write_reg(prd_pkg::CFG_INV_Y, cfg_t'(24'd1));
    write_reg(prd_pkg::CFG_CTR_X, cfg_t'(16'hFFFF));
    write_reg(prd_pkg::CFG_CTR_Y, cfg_t'(16'hFFFF));
    write_reg(prd_pkg::CFG_GL_MODE, cfg_t'(1'b1));
    for (int i = 0; i < 8; i++)
      send_pixel(i[0] ? 12'd4095 : 12'd0, pix_t'(100 * i), 1'b0, z);
    pix.valid <= 0;
    drain();

    // Random phases under several camera settings
    for (int ph = 0; ph < 6; ph++) begin
      repeat (PIPE_LAT + 5) @(posedge clk_i);
      stall_en = (ph != 2);
      if (ph == 0) begin
        write_reg(prd_pkg::CFG_RIGHT, prd_pkg::RIGHT_RST);
        write_reg(prd_pkg::CFG_UP, prd_pkg::UP_RST);
        write_reg(prd_pkg::CFG_FORWARD, prd_pkg::FORWARD_RST);
        write_reg(prd_pkg::CFG_CTR_X, cfg_t'(16'd32768));
        write_reg(prd_pkg::CFG_CTR_Y, cfg_t'(16'd32768));
        write_reg(prd_pkg::CFG_INV_X, cfg_t'(24'd8192));
        write_reg(prd_pkg::CFG_INV_Y, cfg_t'(24'd8192));
        write_reg(prd_pkg::CFG_GL_MODE, '0);
      end else begin
        write_reg(prd_pkg::CFG_RIGHT, rand_vec());
        write_reg(prd_pkg::CFG_UP, rand_vec());
        write_reg(prd_pkg::CFG_FORWARD, rand_vec());
        write_reg(prd_pkg::CFG_CTR_X, cfg_t'($urandom));
        write_reg(prd_pkg::CFG_CTR_Y, cfg_t'($urandom));
        write_reg(prd_pkg::CFG_INV_X,
                  cfg_t'((ph == 5) ? 32'hFF_FFFF : $urandom_range(1, 32'hFF_FFFF)));
        write_reg(prd_pkg::CFG_INV_Y,
                  cfg_t'((ph == 5) ? 32'd1 : $urandom_range(1, 65535)));
        write_reg(prd_pkg::CFG_GL_MODE, cfg_t'(ph[0]));
      end
      random_pixels(70);
      drain();
    end
    pix.valid <= 0;
    drain();
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
